/* design/mvs_pkg.sv */
// Shared types, constants and codes for the record mean/variance/deviation block.
package mvs_pkg;

    // Default parameter values
    localparam int DEF_MAX_SAMPLES = 8;
    localparam int DEF_SAMPLE_BITS = 16;

    // Fixed field widths of the ports
    localparam int IN_W   = 16;
    localparam int IDX_W  = 16;
    localparam int MEAN_W = 24;
    localparam int VAR_W  = 38;
    localparam int DEV_W  = 23;

    // Fraction bits of the fixed-point results
    localparam int FRAC_BITS = 8;

    // Saturation value of the record index
    localparam logic [IDX_W-1:0] IDX_MAX = {IDX_W{1'b1}};

    // Register port
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = PADDR_W - 2;
    localparam int CFG_W     = 4;

    localparam logic [REG_IDX_W-1:0] REG_SAMPLES_PER_RECORD = '0;
    localparam logic [CFG_W-1:0]     SPR_RESET              = 4'd5;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_MUL,
        ST_MEAN,
        ST_VAR,
        ST_ROOT,
        ST_EMIT
    } state_t;

    // Operations of the shared divide/square-root unit
    typedef enum logic {
        OP_DIV,
        OP_SQRT
    } op_t;

    // Command from the sequencer to the shared unit
    typedef struct packed {
        logic start;
        op_t  op;
    } unit_cmd_t;

endpackage

/* design/record_mean_variance_stddev.sv */
// Top level: per-record mean, variance and standard deviation with running best records.
//
// Samples arrive one beat at a time and are summed and squared into the current
// record. A sample that does not close a record stalls the input while it is
// accumulated. A sample that closes a record stalls it through the ACCUM, MUL,
// MEAN, VAR, ROOT and EMIT states, plus any wait for the previous result to be
// read. Most of that stall is set by the shared divide/square-root unit, which
// produces one bit per cycle for the mean quotient, then the variance quotient,
// then the square root. The result sits in an output register, so the next
// record's samples are taken while it waits to be read. The record length
// register lives at byte address 0.
module record_mean_variance_stddev
    import mvs_pkg::*;
#(
    parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
)
(
    input  logic               clk,
    input  logic               rst_n,
    // register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    // sample input
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [IN_W-1:0]    sample,
    // result output
    output logic               out_valid,
    input  logic               out_stall,
    output logic [IDX_W-1:0]   record_index,
    output logic [MEAN_W-1:0]  mean_q8,
    output logic [VAR_W-1:0]   variance_q8,
    output logic [DEV_W-1:0]   deviation_q8,
    output logic [IDX_W-1:0]   top_mean_index,
    output logic [MEAN_W-1:0]  top_mean_q8,
    output logic [IDX_W-1:0]   top_deviation_index,
    output logic [DEV_W-1:0]   top_deviation_q8
);

    localparam int CNT_W      = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W      = SAMPLE_BITS + CNT_W;
    localparam int SQ_W       = 2 * SAMPLE_BITS + CNT_W;
    localparam int NN_W       = 2 * CNT_W;
    localparam int NUM_W      = SQ_W + CNT_W;
    localparam int MEAN_DIV_W = SUM_W + FRAC_BITS;
    localparam int VAR_Q_W    = NUM_W + FRAC_BITS;
    localparam int XW         = VAR_Q_W + FRAC_BITS;
    localparam int ROOT_W     = XW / 2;
    localparam int ITER_W     = $clog2(XW + 1);

    localparam logic [CNT_W-1:0] MAX_LEN = CNT_W'(MAX_SAMPLES);

    state_t                   state_reg;
    state_t                   state_next;

    logic [CFG_W-1:0]         spr_reg;

    logic [SAMPLE_BITS-1:0]   sample_reg;
    logic [2*SAMPLE_BITS-1:0] sq_reg;
    logic [SUM_W-1:0]         sum_reg;
    logic [SQ_W-1:0]          sumsq_reg;
    logic [CNT_W-1:0]         seen_reg;
    logic [CNT_W-1:0]         n_reg;
    logic [NUM_W-1:0]         prod_reg;
    logic [NUM_W-1:0]         sq2_reg;
    logic [NN_W-1:0]          nn_reg;
    logic [NUM_W-1:0]         num_reg;
    logic [MEAN_DIV_W-1:0]    mean_reg;
    logic [VAR_Q_W-1:0]       var_reg;

    logic [IDX_W-1:0]         rec_cnt_reg;
    logic                     best_valid_reg;
    logic [MEAN_DIV_W-1:0]    best_mean_reg;
    logic [IDX_W-1:0]         best_mean_idx_reg;
    logic [ROOT_W-1:0]        best_dev_reg;
    logic [IDX_W-1:0]         best_dev_idx_reg;

    logic                     out_valid_reg;
    logic [IDX_W-1:0]         record_index_reg;
    logic [MEAN_W-1:0]        mean_q8_reg;
    logic [VAR_W-1:0]         variance_q8_reg;
    logic [DEV_W-1:0]         deviation_q8_reg;
    logic [IDX_W-1:0]         top_mean_index_reg;
    logic [MEAN_W-1:0]        top_mean_q8_reg;
    logic [IDX_W-1:0]         top_deviation_index_reg;
    logic [DEV_W-1:0]         top_deviation_q8_reg;

    logic [SAMPLE_BITS-1:0]   s_in;
    logic [2*SAMPLE_BITS-1:0] s_ext;
    logic [NUM_W-1:0]         sumsq_ext;
    logic [NUM_W-1:0]         sum_ext;
    logic [CNT_W-1:0]         len;
    logic [CNT_W-1:0]         cnt_inc;
    logic                     rec_end;
    logic                     accept;
    logic                     emit_go;
    logic                     new_best_mean;
    logic                     new_best_dev;
    logic [ROOT_W-1:0]        dev_val;

    logic [REG_IDX_W-1:0]     reg_idx;
    logic                     cfg_wr;

    unit_cmd_t                unit_cmd;
    logic [XW-1:0]            unit_x;
    logic [NN_W-1:0]          unit_div;
    logic [ITER_W-1:0]        unit_iters;
    logic                     unit_done;
    logic [XW-1:0]            unit_q;

    // Register port decode
    assign reg_idx = paddr[PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && (reg_idx == REG_SAMPLES_PER_RECORD);
    assign pready  = 1'b1;
    assign prdata  = (reg_idx == REG_SAMPLES_PER_RECORD) ? PDATA_W'(spr_reg) : '0;

    // Sample and operand extensions
    assign s_in      = SAMPLE_BITS'(sample);
    assign s_ext     = (2*SAMPLE_BITS)'(s_in);
    assign sumsq_ext = NUM_W'(sumsq_reg);
    assign sum_ext   = NUM_W'(sum_reg);

    // Clamp the record length to 1..MAX_SAMPLES
    always_comb
    begin
        if (spr_reg == '0)
        begin
            len = CNT_W'(1);
        end
        else if (int'(spr_reg) > MAX_SAMPLES)
        begin
            len = MAX_LEN;
        end
        else
        begin
            len = CNT_W'(spr_reg);
        end
    end

    assign cnt_inc = seen_reg + CNT_W'(1);
    assign rec_end = (cnt_inc >= len);
    assign accept  = in_valid && (state_reg == ST_IDLE);
    assign dev_val = ROOT_W'(unit_q);

    // Best-record comparisons, earlier record wins a tie
    assign new_best_mean = !best_valid_reg || (mean_reg > best_mean_reg);
    assign new_best_dev  = !best_valid_reg || (dev_val > best_dev_reg);

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and unit commands
    always_comb
    begin
        state_next = state_reg;
        unit_cmd   = '{start: 1'b0, op: OP_DIV};
        unit_x     = '0;
        unit_div   = '0;
        unit_iters = '0;
        emit_go    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_ACCUM;
                end
            end
            ST_ACCUM:
            begin
                state_next = rec_end ? ST_MUL : ST_IDLE;
            end
            ST_MUL:
            begin
                unit_cmd   = '{start: 1'b1, op: OP_DIV};
                unit_x     = XW'({sum_reg, {FRAC_BITS{1'b0}}}) << (XW - MEAN_DIV_W);
                unit_div   = NN_W'(n_reg);
                unit_iters = ITER_W'(MEAN_DIV_W);
                state_next = ST_MEAN;
            end
            ST_MEAN:
            begin
                if (unit_done)
                begin
                    unit_cmd   = '{start: 1'b1, op: OP_DIV};
                    unit_x     = XW'({num_reg, {FRAC_BITS{1'b0}}}) << (XW - VAR_Q_W);
                    unit_div   = nn_reg;
                    unit_iters = ITER_W'(VAR_Q_W);
                    state_next = ST_VAR;
                end
            end
            ST_VAR:
            begin
                if (unit_done)
                begin
                    unit_cmd   = '{start: 1'b1, op: OP_SQRT};
                    unit_x     = {unit_q[VAR_Q_W-1:0], {FRAC_BITS{1'b0}}};
                    unit_iters = ITER_W'(ROOT_W);
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                if (unit_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    emit_go    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Configuration, accumulators, record counter, best records and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spr_reg           <= SPR_RESET;
            sum_reg           <= '0;
            sumsq_reg         <= '0;
            seen_reg          <= '0;
            rec_cnt_reg       <= '0;
            best_valid_reg    <= 1'b0;
            best_mean_reg     <= '0;
            best_mean_idx_reg <= '0;
            best_dev_reg      <= '0;
            best_dev_idx_reg  <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                spr_reg <= pwdata[CFG_W-1:0];
            end
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == ST_ACCUM)
            begin
                sum_reg   <= sum_reg + SUM_W'(sample_reg);
                sumsq_reg <= sumsq_reg + SQ_W'(sq_reg);
                seen_reg  <= rec_end ? '0 : cnt_inc;
            end
            if (emit_go)
            begin
                sum_reg        <= '0;
                sumsq_reg      <= '0;
                best_valid_reg <= 1'b1;
                out_valid_reg  <= 1'b1;
                if (rec_cnt_reg != IDX_MAX)
                begin
                    rec_cnt_reg <= rec_cnt_reg + IDX_W'(1);
                end
                if (new_best_mean)
                begin
                    best_mean_reg     <= mean_reg;
                    best_mean_idx_reg <= rec_cnt_reg;
                end
                if (new_best_dev)
                begin
                    best_dev_reg     <= dev_val;
                    best_dev_idx_reg <= rec_cnt_reg;
                end
            end
        end
    end

    // Sample capture, products, quotients and output payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= s_in;
            sq_reg     <= s_ext * s_ext;
        end
        if ((state_reg == ST_ACCUM) && rec_end)
        begin
            n_reg <= cnt_inc;
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= sumsq_ext * n_reg;
            sq2_reg  <= sum_ext * sum_ext;
            nn_reg   <= NN_W'(n_reg) * NN_W'(n_reg);
        end
        if (state_reg == ST_MEAN)
        begin
            num_reg <= prod_reg - sq2_reg;
            if (unit_done)
            begin
                mean_reg <= MEAN_DIV_W'(unit_q);
            end
        end
        if ((state_reg == ST_VAR) && unit_done)
        begin
            var_reg <= unit_q[VAR_Q_W-1:0];
        end
        if (emit_go)
        begin
            record_index_reg        <= rec_cnt_reg;
            mean_q8_reg             <= MEAN_W'(mean_reg);
            variance_q8_reg         <= VAR_W'(var_reg);
            deviation_q8_reg        <= DEV_W'(dev_val);
            top_mean_index_reg      <= new_best_mean ? rec_cnt_reg : best_mean_idx_reg;
            top_mean_q8_reg         <= MEAN_W'(new_best_mean ? mean_reg : best_mean_reg);
            top_deviation_index_reg <= new_best_dev ? rec_cnt_reg : best_dev_idx_reg;
            top_deviation_q8_reg    <= DEV_W'(new_best_dev ? dev_val : best_dev_reg);
        end
    end

    // Shared divide/square-root unit
    mvs_divsqrt #(
        .XW     (XW),
        .DIV_W  (NN_W),
        .ITER_W (ITER_W)
    ) u_divsqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (unit_cmd),
        .x_in    (unit_x),
        .divisor (unit_div),
        .iters   (unit_iters),
        .done    (unit_done),
        .q       (unit_q)
    );

    // Drive the ports
    assign in_stall            = (state_reg != ST_IDLE);
    assign out_valid           = out_valid_reg;
    assign record_index        = record_index_reg;
    assign mean_q8             = mean_q8_reg;
    assign variance_q8         = variance_q8_reg;
    assign deviation_q8        = deviation_q8_reg;
    assign top_mean_index      = top_mean_index_reg;
    assign top_mean_q8         = top_mean_q8_reg;
    assign top_deviation_index = top_deviation_index_reg;
    assign top_deviation_q8    = top_deviation_q8_reg;

endmodule

/* design/mvs_divsqrt.sv */
// Shared restoring divider and digit-by-digit square root, one result bit per cycle.
module mvs_divsqrt
    import mvs_pkg::*;
#(
    parameter int XW     = 56,
    parameter int DIV_W  = 8,
    parameter int ITER_W = $clog2(XW + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  unit_cmd_t         cmd,
    input  logic [XW-1:0]     x_in,
    input  logic [DIV_W-1:0]  divisor,
    input  logic [ITER_W-1:0] iters,
    output logic              done,
    output logic [XW-1:0]     q
);

    localparam int RM_A = XW / 2 + 3;
    localparam int RM_B = DIV_W + 2;
    localparam int RM_W = (RM_A > RM_B) ? RM_A : RM_B;

    logic              busy_reg;
    logic              done_reg;
    op_t               op_reg;
    logic [ITER_W-1:0] cnt_reg;
    logic [XW-1:0]     x_reg;
    logic [DIV_W-1:0]  d_reg;
    logic [RM_W-1:0]   rem_reg;
    logic [XW-1:0]     q_reg;

    logic [RM_W-1:0]   rem_sh;
    logic [RM_W-1:0]   trial;
    logic [RM_W:0]     diff;
    logic              fits;
    logic [XW-1:0]     x_shift;

    // Shift in the next digit, compare against the trial term and subtract
    always_comb
    begin
        if (op_reg == OP_SQRT)
        begin
            rem_sh  = {rem_reg[RM_W-3:0], x_reg[XW-1 -: 2]};
            trial   = RM_W'({q_reg, 2'b01});
            x_shift = x_reg << 2;
        end
        else
        begin
            rem_sh  = {rem_reg[RM_W-2:0], x_reg[XW-1]};
            trial   = RM_W'(d_reg);
            x_shift = x_reg << 1;
        end
        diff = {1'b0, rem_sh} - {1'b0, trial};
        fits = ~diff[RM_W];
    end

    // Iteration control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= OP_DIV;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= iters;
                op_reg   <= cmd.op;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - ITER_W'(1);
                if (cnt_reg == ITER_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operand, remainder and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            x_reg   <= x_in;
            d_reg   <= divisor;
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            x_reg   <= x_shift;
            rem_reg <= fits ? diff[RM_W-1:0] : rem_sh;
            q_reg   <= {q_reg[XW-2:0], fits};
        end
    end

    assign done = done_reg;
    assign q    = q_reg;

endmodule

/* design/mvs_checker.sv */
// Port-level checks for the record statistics block, bound to the top level.
module mvs_checker
    import mvs_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input logic [IDX_W-1:0]  record_index,
    input logic [MEAN_W-1:0] mean_q8,
    input logic [MEAN_W-1:0] top_mean_q8,
    input logic [DEV_W-1:0]  deviation_q8,
    input logic [DEV_W-1:0]  top_deviation_q8
);

    // An accepted sample keeps the input stalled while it is accumulated
    a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after an accepted sample");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(record_index) && $stable(mean_q8))
        else $error("stalled result changed");

    // The best mean covers the record just reported
    a_top_mean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> top_mean_q8 >= mean_q8)
        else $error("top mean below current mean");

    // The best deviation covers the record just reported
    a_top_dev: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> top_deviation_q8 >= deviation_q8)
        else $error("top deviation below current deviation");

endmodule

bind record_mean_variance_stddev mvs_checker u_mvs_checker (.*);
